@@ rtl/blms_pkg.sv @@
// Shared types and constants of the bracket-language machine: payload structs,
// instruction characters, microcode word layout, the microcode ROM and its dispatch table.
// No dependencies; compile first.
package blms_pkg;

	// Default store sizes.
	localparam int unsigned PROGRAM_DEPTH_DEF = 256;
	localparam int unsigned DATA_CELLS_DEF    = 256;
	localparam int unsigned INPUT_DEPTH_DEF   = 256;
	localparam int unsigned NEST_DEPTH_DEF    = 128;

	// Command codes.
	localparam logic [2:0] CMD_PROG    = 3'd0;
	localparam logic [2:0] CMD_INPUT   = 3'd1;
	localparam logic [2:0] CMD_STEP    = 3'd2;
	localparam logic [2:0] CMD_RESTART = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	// Instruction characters.
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       halted;
		logic [8:0] instr_pos;
		logic [7:0] data_pos;
		logic [7:0] cell_value;
		logic       overflow;
	} rsp_t;

	// Microcode layout.
	localparam int unsigned UA_W = 4;

	// Datapath actions.
	localparam logic [3:0] A_IDLE    = 4'd0;
	localparam logic [3:0] A_PAPP    = 4'd1;
	localparam logic [3:0] A_PAIR1   = 4'd2;
	localparam logic [3:0] A_PAIR2   = 4'd3;
	localparam logic [3:0] A_IAPP    = 4'd4;
	localparam logic [3:0] A_FETCH   = 4'd5;
	localparam logic [3:0] A_EXEC    = 4'd6;
	localparam logic [3:0] A_LOAD    = 4'd7;
	localparam logic [3:0] A_RESTART = 4'd8;
	localparam logic [3:0] A_SWEEP   = 4'd9;
	localparam logic [3:0] A_CLEAR   = 4'd10;
	localparam logic [3:0] A_FIN     = 4'd11;

	// Jump conditions.
	localparam logic [2:0] C_ALWAYS     = 3'd0;
	localparam logic [2:0] C_ACCEPT     = 3'd1;
	localparam logic [2:0] C_PAIR       = 3'd2;
	localparam logic [2:0] C_HALTED     = 3'd3;
	localparam logic [2:0] C_MOVE       = 3'd4;
	localparam logic [2:0] C_SWEEP_MORE = 3'd5;
	localparam logic [2:0] C_OUT_FREE   = 3'd6;

	// Microcode addresses.
	localparam logic [UA_W-1:0] U_IDLE    = 4'd0;
	localparam logic [UA_W-1:0] U_PAPP    = 4'd1;
	localparam logic [UA_W-1:0] U_PAIR1   = 4'd2;
	localparam logic [UA_W-1:0] U_PAIR2   = 4'd3;
	localparam logic [UA_W-1:0] U_IAPP    = 4'd4;
	localparam logic [UA_W-1:0] U_FETCH   = 4'd5;
	localparam logic [UA_W-1:0] U_EXEC    = 4'd6;
	localparam logic [UA_W-1:0] U_LOAD    = 4'd7;
	localparam logic [UA_W-1:0] U_RESTART = 4'd8;
	localparam logic [UA_W-1:0] U_SWEEP   = 4'd9;
	localparam logic [UA_W-1:0] U_CLEAR   = 4'd10;
	localparam logic [UA_W-1:0] U_FIN     = 4'd11;

	typedef struct packed {
		logic [3:0]      act;
		logic [2:0]      cond;
		logic [UA_W-1:0] tgt_t;
		logic [UA_W-1:0] tgt_f;
	} uword_t;

	// Control store: condition true jumps to tgt_t, false to tgt_f.
	function automatic uword_t ucode_rom(input logic [UA_W-1:0] addr);
		uword_t w;
		unique case (addr)
			U_IDLE:    w = '{A_IDLE,    C_ACCEPT,     U_IDLE,  U_IDLE};
			U_PAPP:    w = '{A_PAPP,    C_PAIR,       U_PAIR1, U_FIN};
			U_PAIR1:   w = '{A_PAIR1,   C_ALWAYS,     U_PAIR2, U_PAIR2};
			U_PAIR2:   w = '{A_PAIR2,   C_ALWAYS,     U_FIN,   U_FIN};
			U_IAPP:    w = '{A_IAPP,    C_ALWAYS,     U_FIN,   U_FIN};
			U_FETCH:   w = '{A_FETCH,   C_HALTED,     U_FIN,   U_EXEC};
			U_EXEC:    w = '{A_EXEC,    C_MOVE,       U_LOAD,  U_FIN};
			U_LOAD:    w = '{A_LOAD,    C_ALWAYS,     U_FIN,   U_FIN};
			U_RESTART: w = '{A_RESTART, C_ALWAYS,     U_SWEEP, U_SWEEP};
			U_SWEEP:   w = '{A_SWEEP,   C_SWEEP_MORE, U_SWEEP, U_FIN};
			U_CLEAR:   w = '{A_CLEAR,   C_ALWAYS,     U_FIN,   U_FIN};
			U_FIN:     w = '{A_FIN,     C_OUT_FREE,   U_IDLE,  U_FIN};
			default:   w = '{A_IDLE,    C_ACCEPT,     U_IDLE,  U_IDLE};
		endcase
		return w;
	endfunction

	// Entry point of each command's routine; unused codes just report.
	function automatic logic [UA_W-1:0] entry_of(input logic [2:0] cmd);
		logic [UA_W-1:0] a;
		unique case (cmd)
			CMD_PROG:    a = U_PAPP;
			CMD_INPUT:   a = U_IAPP;
			CMD_STEP:    a = U_FETCH;
			CMD_RESTART: a = U_RESTART;
			CMD_CLEAR:   a = U_CLEAR;
			default:     a = U_FIN;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/blms_chan_if.sv @@
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is a parameter; no other dependencies.
interface blms_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/bracket_language_machine_step.sv @@
// Bracket-language tape machine, microcoded. Routines: append (a ']' that pairs also writes both
// partner entries), step (fetch, execute, and for '>' or '<' a load of the new cell; a halted
// machine skips execute), input append, clear, reset machine (sweeps every cell to zero);
// unused codes only report. One item at a time: the next item can be taken the cycle after
// the result is registered. A finished result waits in the output register. After arst_n a
// clearing pass zeros every cell; pointers reset to zero.
module bracket_language_machine_step #(
	parameter int unsigned PROGRAM_DEPTH = blms_pkg::PROGRAM_DEPTH_DEF,
	parameter int unsigned DATA_CELLS    = blms_pkg::DATA_CELLS_DEF,
	parameter int unsigned INPUT_DEPTH   = blms_pkg::INPUT_DEPTH_DEF,
	parameter int unsigned NEST_DEPTH    = blms_pkg::NEST_DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	blms_chan_if.sink    req,
	blms_chan_if.source  rsp
);

	import blms_pkg::*;

	// Address widths (stores) and count widths (lengths that can reach the depth).
	localparam int unsigned PA_W = $clog2(PROGRAM_DEPTH);
	localparam int unsigned PL_W = $clog2(PROGRAM_DEPTH + 1);
	localparam int unsigned DA_W = $clog2(DATA_CELLS);
	localparam int unsigned IA_W = $clog2(INPUT_DEPTH);
	localparam int unsigned IL_W = $clog2(INPUT_DEPTH + 1);
	localparam int unsigned NA_W = $clog2(NEST_DEPTH);
	localparam int unsigned NL_W = $clog2(NEST_DEPTH + 1);

	// Sequencer
	logic [UA_W-1:0] upc_q, upc_nxt;
	uword_t          uw;
	logic            cond_true;
	logic            accept;
	logic            boot_q;

	// Machine state
	logic [PL_W-1:0] plen_q, ip_q;
	logic [NL_W-1:0] depth_q;
	logic [IL_W-1:0] ilen_q, iidx_q;
	logic [DA_W-1:0] dp_q, clr_q;
	logic [7:0]      cur_cell_q;    // mirror of the cell under the pointer
	logic            emit_q, ovf_q;

	// Per-item working registers
	logic [7:0]      val_q;
	logic [PA_W-1:0] pos_q, open_q;
	logic [7:0]      emit_byte_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	// Store ports
	logic            prog_we, prog_re;
	logic [7:0]      prog_rdata;
	logic            part_we, part_re;
	logic [PA_W-1:0] part_waddr, part_wdata, part_rdata;
	logic            nest_we, nest_re;
	logic [PA_W-1:0] nest_rdata;
	logic            inp_we, inp_re;
	logic [7:0]      inp_rdata;
	logic            cell_we, cell_re;
	logic [DA_W-1:0] cell_waddr;
	logic [7:0]      cell_wdata, cell_rdata;

	// Decode
	logic            pfull, nfull, ifull, papp_ovf, pair_close;
	logic [7:0]      op;
	logic            take_jump, is_move, cell_wr, in_avail;
	logic [PL_W-1:0] ip_exec;
	logic [DA_W-1:0] dp_exec;
	logic [7:0]      cell_exec;
	logic            out_free, fin_load;

	assign uw     = ucode_rom(upc_q);
	assign accept = req.valid && req.ready;

	assign req.ready   = (uw.act == A_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Append checks: a full program store refuses anything, a full nesting stack refuses '['.
	assign pfull      = (plen_q == PL_W'(PROGRAM_DEPTH));
	assign nfull      = (depth_q == NL_W'(NEST_DEPTH));
	assign ifull      = (ilen_q == IL_W'(INPUT_DEPTH));
	assign papp_ovf   = pfull || ((val_q == CH_OPEN) && nfull);
	assign pair_close = !pfull && (val_q == CH_CLOSE) && (depth_q != '0);

	// Execute: the opcode and partner arrive from the fetch cycle's reads. An unpaired '[' or an unmatched
	// ']' holds itself as partner, so its jump lands on the next instruction like a no-op.
	assign op        = prog_rdata;
	assign take_jump = ((op == CH_OPEN) && (cur_cell_q == 8'd0)) ||
	                   ((op == CH_CLOSE) && (cur_cell_q != 8'd0));
	assign ip_exec   = (take_jump ? PL_W'(part_rdata) : ip_q) + PL_W'(1);
	assign is_move   = (op == CH_RIGHT) || (op == CH_LEFT);
	assign cell_wr   = (op == CH_INC) || (op == CH_DEC) || (op == CH_IN);
	assign in_avail  = (iidx_q < ilen_q);

	always_comb begin
		dp_exec   = dp_q;
		cell_exec = cur_cell_q;
		unique case (op)
			CH_RIGHT: dp_exec   = (dp_q == DA_W'(DATA_CELLS - 1)) ? '0 : dp_q + DA_W'(1);
			CH_LEFT:  dp_exec   = (dp_q == '0) ? DA_W'(DATA_CELLS - 1) : dp_q - DA_W'(1);
			CH_INC:   cell_exec = cur_cell_q + 8'd1;
			CH_DEC:   cell_exec = cur_cell_q - 8'd1;
			CH_IN:    cell_exec = in_avail ? inp_rdata : 8'd0;
			default:  ;
		endcase
	end

	// The result register frees when empty or drained this cycle; the boot pass leaves no result.
	assign out_free = !rsp_valid_q || rsp.ready;
	assign fin_load = (uw.act == A_FIN) && !boot_q && out_free;

	// Condition select and next micro-address. An accepted item jumps to its command's routine.
	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:     cond_true = 1'b1;
			C_ACCEPT:     cond_true = accept;
			C_PAIR:       cond_true = pair_close;
			C_HALTED:     cond_true = (ip_q >= plen_q);
			C_MOVE:       cond_true = is_move;
			C_SWEEP_MORE: cond_true = (clr_q != DA_W'(DATA_CELLS - 1));
			C_OUT_FREE:   cond_true = boot_q || out_free;
			default:      cond_true = 1'b0;
		endcase
		upc_nxt = cond_true ? uw.tgt_t : uw.tgt_f;
		if ((uw.cond == C_ACCEPT) && cond_true) begin
			upc_nxt = entry_of(req.payload.cmd);
		end
	end

	// Store port control.
	assign prog_we = (uw.act == A_PAPP) && !papp_ovf;
	assign prog_re = (uw.act == A_FETCH);

	always_comb begin
		part_we    = 1'b0;
		part_waddr = PA_W'(plen_q);
		part_wdata = PA_W'(plen_q);
		unique case (uw.act)
			A_PAPP: begin
				// Self-partner for every '[' and for a ']' with nothing to close.
				part_we = !papp_ovf &&
				          ((val_q == CH_OPEN) || ((val_q == CH_CLOSE) && (depth_q == '0)));
			end
			A_PAIR1: begin
				part_we    = 1'b1;
				part_waddr = nest_rdata;
				part_wdata = pos_q;
			end
			A_PAIR2: begin
				part_we    = 1'b1;
				part_waddr = pos_q;
				part_wdata = open_q;
			end
			default: ;
		endcase
	end
	assign part_re = (uw.act == A_FETCH);

	assign nest_we = (uw.act == A_PAPP) && !papp_ovf && (val_q == CH_OPEN);
	assign nest_re = (uw.act == A_PAPP) && pair_close;

	assign inp_we = (uw.act == A_IAPP) && !ifull;
	assign inp_re = (uw.act == A_FETCH);

	// Cells: the sweep writes zeros; execute writes the changed cell; a move reads the new cell.
	assign cell_we    = ((uw.act == A_EXEC) && cell_wr) || (uw.act == A_SWEEP);
	assign cell_waddr = (uw.act == A_SWEEP) ? clr_q : dp_q;
	assign cell_wdata = (uw.act == A_SWEEP) ? 8'd0 : cell_exec;
	assign cell_re    = (uw.act == A_EXEC) && is_move;

	blms_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
		.clk  (clk),
		.we   (prog_we),
		.waddr(PA_W'(plen_q)),
		.wdata(val_q),
		.re   (prog_re),
		.raddr(PA_W'(ip_q)),
		.rdata(prog_rdata)
	);

	blms_ram #(.WIDTH(PA_W), .DEPTH(PROGRAM_DEPTH)) u_partner (
		.clk  (clk),
		.we   (part_we),
		.waddr(part_waddr),
		.wdata(part_wdata),
		.re   (part_re),
		.raddr(PA_W'(ip_q)),
		.rdata(part_rdata)
	);

	blms_ram #(.WIDTH(PA_W), .DEPTH(NEST_DEPTH)) u_nest (
		.clk  (clk),
		.we   (nest_we),
		.waddr(NA_W'(depth_q)),
		.wdata(PA_W'(plen_q)),
		.re   (nest_re),
		.raddr(NA_W'(depth_q - NL_W'(1))),
		.rdata(nest_rdata)
	);

	blms_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH)) u_input (
		.clk  (clk),
		.we   (inp_we),
		.waddr(IA_W'(ilen_q)),
		.wdata(val_q),
		.re   (inp_re),
		.raddr(IA_W'(iidx_q)),
		.rdata(inp_rdata)
	);

	blms_ram #(.WIDTH(8), .DEPTH(DATA_CELLS)) u_cells (
		.clk  (clk),
		.we   (cell_we),
		.waddr(cell_waddr),
		.wdata(cell_wdata),
		.re   (cell_re),
		.raddr(dp_exec),
		.rdata(cell_rdata)
	);

	// Control state. Reset starts the sequencer in the clearing pass with the boot mark set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_SWEEP;
			boot_q      <= 1'b1;
			clr_q       <= '0;
			plen_q      <= '0;
			depth_q     <= '0;
			ilen_q      <= '0;
			iidx_q      <= '0;
			ip_q        <= '0;
			dp_q        <= '0;
			cur_cell_q  <= 8'd0;
			emit_q      <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_nxt;
			unique case (uw.act)
				A_IDLE: begin
					if (accept) begin
						emit_q <= 1'b0;
						ovf_q  <= 1'b0;
					end
				end
				A_PAPP: begin
					if (papp_ovf) begin
						ovf_q <= 1'b1;
					end else begin
						plen_q <= plen_q + PL_W'(1);
						if (val_q == CH_OPEN) begin
							depth_q <= depth_q + NL_W'(1);
						end else if (pair_close) begin
							depth_q <= depth_q - NL_W'(1);
						end
					end
				end
				A_IAPP: begin
					if (ifull) begin
						ovf_q <= 1'b1;
					end else begin
						ilen_q <= ilen_q + IL_W'(1);
					end
				end
				A_EXEC: begin
					ip_q <= ip_exec;
					dp_q <= dp_exec;
					if (cell_wr) begin
						cur_cell_q <= cell_exec;
					end
					if ((op == CH_IN) && in_avail) begin
						iidx_q <= iidx_q + IL_W'(1);
					end
					if (op == CH_OUT) begin
						emit_q <= 1'b1;
					end
				end
				A_LOAD: begin
					// Refresh the mirror after a pointer move.
					cur_cell_q <= cell_rdata;
				end
				A_RESTART: begin
					ip_q       <= '0;
					dp_q       <= '0;
					iidx_q     <= '0;
					cur_cell_q <= 8'd0;
					clr_q      <= '0;
				end
				A_SWEEP: begin
					clr_q <= clr_q + DA_W'(1);
				end
				A_CLEAR: begin
					plen_q  <= '0;
					depth_q <= '0;
					ilen_q  <= '0;
					iidx_q  <= '0;
					ip_q    <= '0;
				end
				A_FIN: begin
					boot_q <= 1'b0;
				end
				default: ;
			endcase

			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q       <= req.payload.value;
			emit_byte_q <= 8'd0;
		end
		if (uw.act == A_PAPP) begin
			pos_q <= PA_W'(plen_q);
		end
		if (uw.act == A_PAIR1) begin
			open_q <= nest_rdata;
		end
		if ((uw.act == A_EXEC) && (op == CH_OUT)) begin
			emit_byte_q <= cur_cell_q;
		end
		if (fin_load) begin
			rsp_q.out_valid  <= emit_q;
			rsp_q.out_byte   <= emit_byte_q;
			rsp_q.halted     <= (ip_q >= plen_q);
			rsp_q.instr_pos  <= 9'(ip_q);
			rsp_q.data_pos   <= 8'(dp_q);
			rsp_q.cell_value <= cur_cell_q;
			rsp_q.overflow   <= ovf_q;
		end
	end

	// The program position never runs past the loaded program.
	a_ip_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		ip_q <= plen_q)
		else $error("instruction pointer beyond program length");

	// The input index never runs past the loaded input.
	a_input_index: assert property (@(posedge clk) disable iff (!arst_n)
		iidx_q <= ilen_q)
		else $error("input index beyond input length");

	// The nesting stack never grows past its depth.
	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= NL_W'(NEST_DEPTH))
		else $error("nesting stack overrun");

	// No item is taken during the boot clearing pass.
	a_boot_closed: assert property (@(posedge clk) disable iff (!arst_n)
		boot_q |-> !req.ready)
		else $error("item accepted during clearing pass");

endmodule

@@ rtl/blms_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module blms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ tb/tb_bracket_language_machine_step.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bracket_language_machine_step; needs blms_pkg and blms_chan_if.
// Directed table, then random programs; a tape-machine predictor checks all but typed rows.
module tb_bracket_language_machine_step;
	import blms_pkg::*;

	// Unused command codes: the block only reports its state for these.
	localparam logic [2:0] CMD_NOP_LO = 3'd5;
	localparam logic [2:0] CMD_NOP_HI = 3'd7;

	localparam int RESET_CYCLES     = 12;
	localparam int RANDOM_ITEMS     = 1450;
	localparam int RECV_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 20;
	// The slowest correct gap between two transactions is a machine reset (a sweep of every cell),
	// or a long receiver hold-off (RECV_HOLD_CYCLES), or the clearing pass after reset.
	// Stack random stalls on top and allow several times that.
	localparam int STALL_LIMIT      = 4000;

	// One row of the directed table. A row with text appends each character as a
	// program byte; otherwise cmd/value is sent count times. Rows marked typed carry
	// a hand-written result: every field zero except halted and overflow.
	typedef struct {
		logic [2:0] cmd;
		logic [7:0] value;
		int         count;
		string      text;
		bit         typed;
		bit         want_halted;
		bit         want_ovf;
	} stim_row_t;

	logic clk;
	logic arst_n;

	blms_chan_if #(.payload_t(req_t)) req_if ();
	blms_chan_if #(.payload_t(rsp_t)) rsp_if ();

	bracket_language_machine_step u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Predictor state: a private copy of the tape machine.
	logic [7:0] tape_prog    [PROGRAM_DEPTH_DEF];
	logic [7:0] tape_partner [PROGRAM_DEPTH_DEF];
	bit         tape_paired  [PROGRAM_DEPTH_DEF];
	logic [8:0] tape_prog_len;
	logic [7:0] tape_nest    [NEST_DEPTH_DEF];
	logic [7:0] tape_nest_depth;
	logic [7:0] tape_input   [INPUT_DEPTH_DEF];
	logic [8:0] tape_in_len;
	logic [8:0] tape_in_idx;
	logic [7:0] tape_cells   [DATA_CELLS_DEF];
	logic [7:0] tape_dp;
	logic [8:0] tape_ip;

	rsp_t expected_replies [$];
	int   error_count    = 0;
	int   replies_seen   = 0;
	int   items_sent     = 0;
	int   send_idle_pct  = 18;
	int   recv_idle_pct  = 73;
	int   hold_requests  = 0;

	// The program ends with an unpaired '[', and its third ']' closes nothing.
	// Input runs dry on the last ','; '<' and '>' wrap the pointer, '+' and '-' the cell.
	stim_row_t directed_rows [18] = '{
		'{CMD_STEP,    8'hFF,    1, "",                     1'b1, 1'b1, 1'b0},
		'{CMD_NOP_HI,  8'h00,    1, "",                     1'b1, 1'b1, 1'b0},
		'{CMD_RESTART, 8'h00,    1, "",                     1'b1, 1'b1, 1'b0},
		'{CMD_INPUT,   8'hFF,    1, "",                     1'b1, 1'b1, 1'b0},
		'{CMD_INPUT,   8'h00,    1, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_INPUT,   8'h01,    1, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_PROG,    8'h00,    1, ",.<-+-.>,,[-][+]]x,[", 1'b0, 1'b0, 1'b0},
		'{CMD_STEP,    8'h00,   20, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_CLEAR,   8'h00,    1, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_RESTART, 8'h00,    1, "",                     1'b1, 1'b1, 1'b0},
		'{CMD_PROG,    CH_OPEN, 128, "",                    1'b0, 1'b0, 1'b0},
		'{CMD_PROG,    CH_OPEN,  1, "",                     1'b1, 1'b0, 1'b1},
		'{CMD_PROG,    CH_INC, 128, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_PROG,    CH_CLOSE, 1, "",                     1'b1, 1'b0, 1'b1},
		'{CMD_INPUT,   8'h5A,  256, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_INPUT,   8'hA5,    1, "",                     1'b1, 1'b0, 1'b1},
		'{CMD_STEP,    8'h00,    2, "",                     1'b0, 1'b0, 1'b0},
		'{CMD_NOP_LO,  8'h7F,    1, "",                     1'b0, 1'b0, 1'b0}
	};

	// Reset machine: pointers and input index to zero, wipe every cell.
	function automatic void tape_restart();
		tape_ip     = '0;
		tape_dp     = '0;
		tape_in_idx = '0;
		foreach (tape_cells[i])
			tape_cells[i] = '0;
	endfunction

	// Clear: drop program, pairing and input; the cells keep their values.
	function automatic void tape_clear();
		tape_prog_len   = '0;
		tape_nest_depth = '0;
		tape_in_len     = '0;
		tape_in_idx     = '0;
		tape_ip         = '0;
		foreach (tape_paired[i])
			tape_paired[i] = 1'b0;
	endfunction

	// Apply one command to the predictor and return the result it must produce.
	function automatic rsp_t tape_apply(input logic [2:0] c, input logic [7:0] v);
		rsp_t       r;
		logic [8:0] ip;
		logic [7:0] dp;
		logic [7:0] op;
		logic [7:0] pos;
		logic [7:0] open_pos;
		r = '0;
		case (c)
			CMD_PROG: begin
				pos = tape_prog_len[7:0];
				if (tape_prog_len >= PROGRAM_DEPTH_DEF) begin
					r.overflow = 1'b1;
				end else if (v == CH_OPEN && tape_nest_depth >= NEST_DEPTH_DEF) begin
					r.overflow = 1'b1;
				end else begin
					if (v == CH_OPEN) begin
						tape_nest[tape_nest_depth] = pos;
						tape_nest_depth++;
					end
					tape_prog[pos]   = v;
					tape_paired[pos] = 1'b0;
					// Close the innermost open bracket; a stray ']' stays unpaired.
					if (v == CH_CLOSE && tape_nest_depth != 0) begin
						tape_nest_depth--;
						open_pos                = tape_nest[tape_nest_depth];
						tape_partner[open_pos]  = pos;
						tape_paired[open_pos]   = 1'b1;
						tape_partner[pos]       = open_pos;
						tape_paired[pos]        = 1'b1;
					end
					tape_prog_len++;
				end
			end
			CMD_INPUT: begin
				if (tape_in_len >= INPUT_DEPTH_DEF) begin
					r.overflow = 1'b1;
				end else begin
					tape_input[tape_in_len[7:0]] = v;
					tape_in_len++;
				end
			end
			CMD_STEP: begin
				// A halted machine holds still.
				if (tape_ip < tape_prog_len) begin
					ip = tape_ip;
					dp = tape_dp;
					op = tape_prog[ip[7:0]];
					case (op)
						CH_RIGHT: dp = dp + 8'd1;
						CH_LEFT:  dp = dp - 8'd1;
						CH_INC:   tape_cells[dp] = tape_cells[dp] + 8'd1;
						CH_DEC:   tape_cells[dp] = tape_cells[dp] - 8'd1;
						CH_OUT: begin
							r.out_valid = 1'b1;
							r.out_byte  = tape_cells[dp];
						end
						CH_IN: begin
							if (tape_in_idx < tape_in_len) begin
								tape_cells[dp] = tape_input[tape_in_idx[7:0]];
								tape_in_idx++;
							end else begin
								tape_cells[dp] = 8'h00;
							end
						end
						CH_OPEN: begin
							if (tape_cells[dp] == 8'h00 && tape_paired[ip[7:0]])
								ip = {1'b0, tape_partner[ip[7:0]]};
						end
						CH_CLOSE: begin
							if (tape_cells[dp] != 8'h00 && tape_paired[ip[7:0]])
								ip = {1'b0, tape_partner[ip[7:0]]};
						end
						default: ;
					endcase
					tape_ip = ip + 9'd1;
					tape_dp = dp;
				end
			end
			CMD_RESTART: tape_restart();
			CMD_CLEAR:   tape_clear();
			default:     ;
		endcase
		r.halted     = (tape_ip >= tape_prog_len);
		r.instr_pos  = tape_ip;
		r.data_pos   = tape_dp;
		r.cell_value = tape_cells[tape_dp];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= 50)
			$display("mismatch at result %0d: %s got %0h expected %0h",
				replies_seen, what, got, want);
	endtask

	// Compare one result with the oldest expectation, field by field.
	task automatic check_reply(input rsp_t got);
		rsp_t want;
		replies_seen++;
		if (expected_replies.size() == 0) begin
			report_mismatch("result with nothing expected", int'(got.instr_pos), 0);
		end else begin
			want = expected_replies.pop_front();
			if (got.out_valid !== want.out_valid)
				report_mismatch("out_valid", int'(got.out_valid), int'(want.out_valid));
			if (got.out_byte !== want.out_byte)
				report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
			if (got.halted !== want.halted)
				report_mismatch("halted", int'(got.halted), int'(want.halted));
			if (got.instr_pos !== want.instr_pos)
				report_mismatch("instr_pos", int'(got.instr_pos), int'(want.instr_pos));
			if (got.data_pos !== want.data_pos)
				report_mismatch("data_pos", int'(got.data_pos), int'(want.data_pos));
			if (got.cell_value !== want.cell_value)
				report_mismatch("cell_value", int'(got.cell_value), int'(want.cell_value));
			if (got.overflow !== want.overflow)
				report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
		end
	endtask

	// Offer one transaction, idling first at random, and hold it until accepted.
	// On acceptance advance the predictor and queue what the block must return.
	// Valid is left high: the caller either offers again at once or drops it.
	task automatic send_item(input logic [2:0] c, input logic [7:0] v,
			input bit typed = 1'b0, input rsp_t want = '0);
		rsp_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= '{cmd: c, value: v};
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		pred = tape_apply(c, v);
		expected_replies.push_back(typed ? want : pred);
		if (c <= CMD_CLEAR)
			items_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drive every input to a known value from the start; hold reset low.
	initial begin
		arst_n         <= 1'b0;
		req_if.valid   <= 1'b0;
		req_if.payload <= '0;
		rsp_if.ready   <= 1'b0;
	end

	// Result side: check each accepted transaction, then choose the next ready.
	// A hold request from the stimulus drops ready for a long stretch so the
	// block backs up and stalls its input.
	initial begin
		int holds_done = 0;
		int hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				check_reply(rsp_if.payload);
			if (hold_left == 0 && holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left  = RECV_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	initial begin
		int quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus.
	initial begin
		stim_row_t  row;
		rsp_t       want;
		int         base;
		int         cur_phase;
		int         new_phase;
		int         plen;
		int         open_cnt;
		int         step_cap;
		int         steps;
		int         pick;
		logic [7:0] b;

		tape_restart();
		tape_clear();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: walk the table. The block is still in its clearing pass
		// here, so the first transaction simply waits for ready.
		foreach (directed_rows[idx]) begin
			row  = directed_rows[idx];
			want = '{out_valid: 1'b0, out_byte: 8'h00, halted: row.want_halted,
				instr_pos: 9'd0, data_pos: 8'h00, cell_value: 8'h00,
				overflow: row.want_ovf};
			if (row.text.len() != 0) begin
				for (int i = 0; i < row.text.len(); i++)
					send_item(CMD_PROG, row.text[i], row.typed, want);
			end else begin
				repeat (row.count)
					send_item(row.cmd, row.value, row.typed, want);
			end
		end

		// Random part: sessions of clear, input, a random program with mostly
		// balanced brackets, an optional machine reset, then steps until the
		// program halts or a step budget runs out. A little noise on top.
		base      = items_sent;
		cur_phase = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			new_phase = (items_sent - base) * 3 / RANDOM_ITEMS;
			if (new_phase != cur_phase) begin
				cur_phase = new_phase;
				// Pause the sender until every result is back, then swap the
				// idling pattern and ask the receiver for a long hold-off.
				if (expected_replies.size() != 0) begin
					req_if.valid <= 1'b0;
					while (expected_replies.size() != 0)
						@(posedge clk);
				end
				send_idle_pct = (cur_phase == 1) ? 73 : 0;
				recv_idle_pct = (cur_phase == 1) ? 18 : 0;
				hold_requests++;
			end

			// Now and then keep the old program so the store fills and overflows.
			if ($urandom_range(99) < 85)
				send_item(CMD_CLEAR, 8'($urandom_range(255)));
			repeat ($urandom_range(6))
				send_item(CMD_INPUT, 8'($urandom_range(255)));

			plen     = ($urandom_range(99) < 5) ? $urandom_range(200, 60) : $urandom_range(24, 1);
			open_cnt = 0;
			for (int i = 0; i < plen; i++) begin
				pick = $urandom_range(99);
				if (pick < 12 && open_cnt < 6) begin
					b = CH_OPEN;
					open_cnt++;
				end else if (pick < 24 && open_cnt > 0) begin
					b = CH_CLOSE;
					open_cnt--;
				end else if (pick < 27) begin
					// Any byte at all: no-ops, stray brackets and the like.
					b = 8'($urandom_range(255));
				end else begin
					case ($urandom_range(5))
						0:       b = CH_INC;
						1:       b = CH_DEC;
						2:       b = CH_RIGHT;
						3:       b = CH_LEFT;
						4:       b = CH_OUT;
						default: b = CH_IN;
					endcase
				end
				send_item(CMD_PROG, b);
			end
			repeat (open_cnt)
				send_item(CMD_PROG, CH_CLOSE);

			if ($urandom_range(99) < 70)
				send_item(CMD_RESTART, 8'($urandom_range(255)));

			step_cap = $urandom_range(80, 10);
			steps    = 0;
			while (tape_ip < tape_prog_len && steps < step_cap) begin
				send_item(CMD_STEP, 8'($urandom_range(255)));
				steps++;
			end
			if ($urandom_range(99) < 10)
				send_item(CMD_STEP, 8'($urandom_range(255)));

			if ($urandom_range(99) < 10)
				repeat ($urandom_range(3, 1))
					send_item(3'($urandom_range(7)), 8'($urandom_range(255)));
		end

		// Drop valid, let every result come home, then keep idling through a drain period
		// for anything stray to show up.
		req_if.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/blms_pkg.sv
rtl/blms_chan_if.sv
rtl/blms_ram.sv
rtl/bracket_language_machine_step.sv
tb/tb_bracket_language_machine_step.sv
